// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- design/sli_pkg.sv -----
// ----------------------------------------------------------------------------
// sli_pkg
// Types and constants shared by the sorted list cells and controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package sli_pkg;

  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned KEY_WIDTH   = 32;
  localparam int unsigned IDX_W       = $clog2(CAPACITY);
  localparam int unsigned CNT_W       = $clog2(CAPACITY + 1);
  localparam int unsigned OP_W        = 2;
  localparam int unsigned KEY_FIELD_W = 32;
  localparam int unsigned POS_W       = 4;
  localparam int unsigned STATUS_W    = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TAKE   = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ACT_HOLD   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_TAKE   = 2'd2,
    ACT_DEL_EQ = 2'd3
  } action_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // Broadcast from the controller to every cell
  typedef struct packed {
    action_e              action;
    logic [KEY_WIDTH-1:0] key;
    logic [POS_W-1:0]     pos;
    logic [CNT_W-1:0]     count;
  } cell_cmd_t;

endpackage

// ----- design/sli_cell.sv -----
// ----------------------------------------------------------------------------
// sli_cell
// One list slot: compares its key, shifts left/right with its neighbors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sli_cell (
  input  logic                         clk_i,
  input  logic [sli_pkg::IDX_W-1:0]    idx_i,
  input  sli_pkg::cell_cmd_t           cmd_i,
  input  logic                         lt_left_i,
  input  logic [sli_pkg::KEY_WIDTH-1:0] left_key_i,
  input  logic [sli_pkg::KEY_WIDTH-1:0] right_key_i,
  output logic [sli_pkg::KEY_WIDTH-1:0] entry_o,
  output logic                         lt_o,
  output logic                         eq_o,
  output logic [sli_pkg::KEY_WIDTH-1:0] tap_o
);
  import sli_pkg::*;

  logic [KEY_WIDTH-1:0] entry_q, entry_d;
  logic                 valid;

  assign valid   = CNT_W'(idx_i) < cmd_i.count;
  assign lt_o    = valid && (entry_q < cmd_i.key);
  assign eq_o    = valid && (entry_q == cmd_i.key);
  assign tap_o   = (POS_W'(idx_i) == cmd_i.pos) ? entry_q : '0;
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    case (cmd_i.action)
      ACT_INSERT: begin
        if (!lt_left_i) begin
          entry_d = left_key_i;
        end else if (!lt_o) begin
          entry_d = cmd_i.key;
        end
      end
      ACT_TAKE: begin
        if (POS_W'(idx_i) >= cmd_i.pos) begin
          entry_d = right_key_i;
        end
      end
      ACT_DEL_EQ: begin
        // first equal key and everything after it close up by one
        if (!lt_o) begin
          entry_d = right_key_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ----- design/sli_ctrl.sv -----
// ----------------------------------------------------------------------------
// sli_ctrl
// Request sequencer: captures a transaction, drives the cells, builds result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sli_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [sli_pkg::OP_W-1:0]        opcode_i,
  input  logic [sli_pkg::KEY_FIELD_W-1:0] key_i,
  input  logic [sli_pkg::POS_W-1:0]       position_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [sli_pkg::KEY_FIELD_W-1:0] taken_key_o,
  output logic [sli_pkg::STATUS_W-1:0]    status_o,
  output logic [sli_pkg::CNT_W-1:0]       entry_count_o,
  output logic [sli_pkg::CNT_W-1:0]       removed_count_o,
  input  logic                            any_eq_i,
  input  logic [sli_pkg::KEY_WIDTH-1:0]   tap_key_i,
  output sli_pkg::cell_cmd_t              cmd_o
);
  import sli_pkg::*;

  state_e               state_q, state_d;
  op_e                  op_q, op_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     removed_q, removed_d;
  logic                 out_valid_q, out_valid_d;
  logic [KEY_FIELD_W-1:0] out_taken_q, out_taken_d;
  status_e              out_status_q, out_status_d;
  logic [CNT_W-1:0]     out_count_q, out_count_d;
  logic [CNT_W-1:0]     out_removed_q, out_removed_d;
  logic                 out_free;
  action_e              action;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    key_d         = key_q;
    pos_d         = pos_q;
    count_d       = count_q;
    removed_d     = removed_q;
    out_valid_d   = out_valid_q && out_stall_i;
    out_taken_d   = out_taken_q;
    out_status_d  = out_status_q;
    out_count_d   = out_count_q;
    out_removed_d = out_removed_q;
    action        = ACT_HOLD;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d      = op_e'(opcode_i);
          key_d     = KEY_WIDTH'(key_i);
          pos_d     = position_i;
          removed_d = '0;
          state_d   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if ((op_q == OP_REMOVE) && any_eq_i) begin
          // one equal key leaves per cycle
          action    = ACT_DEL_EQ;
          count_d   = count_q - CNT_W'(1);
          removed_d = removed_q + CNT_W'(1);
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_taken_d  = '0;
          out_status_d = STATUS_OK;
          state_d      = ST_IDLE;
          case (op_q)
            OP_INSERT: begin
              if (count_q == CNT_W'(CAPACITY)) begin
                out_status_d = STATUS_FULL;
              end else begin
                action  = ACT_INSERT;
                count_d = count_q + CNT_W'(1);
              end
            end
            OP_TAKE: begin
              if (CNT_W'(pos_q) >= count_q) begin
                out_status_d = STATUS_RANGE;
              end else begin
                action      = ACT_TAKE;
                count_d     = count_q - CNT_W'(1);
                removed_d   = CNT_W'(1);
                out_taken_d = KEY_FIELD_W'(tap_key_i);
              end
            end
            default: ;
          endcase
          out_count_d   = count_d;
          out_removed_d = removed_d;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q          <= op_d;
    key_q         <= key_d;
    pos_q         <= pos_d;
    removed_q     <= removed_d;
    out_taken_q   <= out_taken_d;
    out_status_q  <= out_status_d;
    out_count_q   <= out_count_d;
    out_removed_q <= out_removed_d;
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign taken_key_o     = out_taken_q;
  assign status_o        = out_status_q;
  assign entry_count_o   = out_count_q;
  assign removed_count_o = out_removed_q;

  assign cmd_o.action = action;
  assign cmd_o.key    = key_q;
  assign cmd_o.pos    = pos_q;
  assign cmd_o.count  = count_q;

  `ASSERT_PROP(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(CAPACITY), "count above capacity")
  `ASSERT_IMPLY(a_result_from_exec, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == ST_EXEC), "result without execute")
  `ASSERT_IMPLY(a_full_count, clk_i, rst_ni, out_valid_q && (out_status_q == STATUS_FULL), out_count_q == CNT_W'(CAPACITY), "full status with room left")
  `ASSERT_IMPLY(a_del_needs_match, clk_i, rst_ni, action == ACT_DEL_EQ, any_eq_i && (count_q != '0), "delete without matching key")

endmodule

// ----- design/sorted_list_insert_remove_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_unit
// Ascending list of keys held in a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request transaction:
//   opcode_i (insert, remove all equal, take at position), key_i, position_i.
//   Output channel (out_valid_o / out_stall_i) returns one result transaction
//   per request: taken_key_o, status_o, entry_count_o, removed_count_o.
//   Sequence:
//     insert, take, unused opcode: the request is captured while idle and
//     its result is registered in the execute state; the next request is
//     taken only once the sequencer is back in idle.
//     remove: the execute state first drops the matching keys one at a time,
//     the cell chain closing up one position per cycle, then registers the result.
//   Requests are taken only while the sequencer is idle; in_stall_o is high
//   while a request executes.
//   A stalled result sits in the output register; a new request may be accepted
//   meanwhile, but its result waits until the register frees.
//   Reset (rst_ni low, async) empties the list (count = 0) and drops any
//   pending result; the cell contents are not cleared and are never read
//   past the count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sorted_list_insert_remove_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [sli_pkg::OP_W-1:0]        opcode_i,
  input  logic [sli_pkg::KEY_FIELD_W-1:0] key_i,
  input  logic [sli_pkg::POS_W-1:0]       position_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [sli_pkg::KEY_FIELD_W-1:0] taken_key_o,
  output logic [sli_pkg::STATUS_W-1:0]    status_o,
  output logic [sli_pkg::CNT_W-1:0]       entry_count_o,
  output logic [sli_pkg::CNT_W-1:0]       removed_count_o
);
  import sli_pkg::*;

  cell_cmd_t            cmd;
  logic [KEY_WIDTH-1:0] entry [CAPACITY];
  logic [KEY_WIDTH-1:0] tap   [CAPACITY];
  logic [CAPACITY-1:0]  lt;
  logic [CAPACITY-1:0]  eq;
  logic                 any_eq;
  logic [KEY_WIDTH-1:0] tap_key;

  // Sequencer: owns the count, the request and the result register
  sli_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .key_i           (key_i),
    .position_i      (position_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .taken_key_o     (taken_key_o),
    .status_o        (status_o),
    .entry_count_o   (entry_count_o),
    .removed_count_o (removed_count_o),
    .any_eq_i        (any_eq),
    .tap_key_i       (tap_key),
    .cmd_o           (cmd)
  );

  // Cell chain: slot 0 holds the smallest key. Insert shifts toward the
  // tail, take/remove pull from the tail side.
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    logic                 lt_left;
    logic [KEY_WIDTH-1:0] left_key;
    logic [KEY_WIDTH-1:0] right_key;

    if (gi == 0) begin : g_head
      assign lt_left  = 1'b1;
      assign left_key = '0;
    end else begin : g_mid
      assign lt_left  = lt[gi-1];
      assign left_key = entry[gi-1];
    end

    if (gi == CAPACITY - 1) begin : g_tail
      assign right_key = '0;   // slot past the end, never valid afterwards
    end else begin : g_body
      assign right_key = entry[gi+1];
    end

    sli_cell u_cell (
      .clk_i       (clk_i),
      .idx_i       (IDX_W'(gi)),
      .cmd_i       (cmd),
      .lt_left_i   (lt_left),
      .left_key_i  (left_key),
      .right_key_i (right_key),
      .entry_o     (entry[gi]),
      .lt_o        (lt[gi]),
      .eq_o        (eq[gi]),
      .tap_o       (tap[gi])
    );
  end

  assign any_eq = |eq;

  // Only the addressed cell drives a nonzero tap
  always_comb begin
    tap_key = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tap_key = tap_key | tap[i];
    end
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_list_insert_remove_unit. A directed prelude
// covers the empty list, equal keys, the full list, out-of-range takes and the
// unused opcode. Random requests follow, in phases that alternately fill and
// drain the list. Both channels idle at random, and the result side holds off
// once for a long stretch. Every result is checked in order against a
// shadow copy of the list.
// ----------------------------------------------------------------------------
module tb;
  import sli_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;  // decodes to nothing in the unit
  localparam int unsigned MAX_GAP         = 12;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned RANDOM_ITEMS    = 1300;
  localparam int unsigned PHASE_LEN       = 100;
  localparam int unsigned DRAIN_CYCLES    = 40;
  localparam int unsigned CYCLE_LIMIT     = 400000;

  // One result transaction
  typedef struct packed {
    logic [KEY_FIELD_W-1:0] taken_key;
    status_e                status;
    logic [CNT_W-1:0]       entry_count;
    logic [CNT_W-1:0]       removed_count;
  } reply_t;

  // Shadow copy of the list plus the queue of replies still owed by the unit
  class list_tracker;
    logic [KEY_WIDTH-1:0] stored_keys [CAPACITY];
    int unsigned          fill;
    reply_t               expected_replies [$];
    int unsigned          mismatches;

    function new();
      fill       = 0;
      mismatches = 0;
    endfunction

    function int unsigned entry_count();
      return fill;
    endfunction

    function int unsigned pending();
      return expected_replies.size();
    endfunction

    function reply_t predict_list_op(logic [OP_W-1:0] op, logic [KEY_FIELD_W-1:0] key,
                                     logic [POS_W-1:0] pos);
      reply_t               r;
      int unsigned          slot;
      int unsigned          kept;
      logic [KEY_WIDTH-1:0] k;
      r.taken_key     = '0;
      r.status        = STATUS_OK;
      r.removed_count = '0;
      k = key[KEY_WIDTH-1:0];
      case (op)
        OP_INSERT: begin
          if (fill >= CAPACITY) begin
            r.status = STATUS_FULL;
          end else begin
            // new key lands in front of its equals
            slot = 0;
            while (slot < fill && k > stored_keys[slot]) slot++;
            for (int j = fill; j > slot; j--) stored_keys[j] = stored_keys[j-1];
            stored_keys[slot] = k;
            fill++;
          end
        end
        OP_REMOVE: begin
          kept = 0;
          for (int j = 0; j < fill; j++) begin
            if (stored_keys[j] == k) r.removed_count++;
            else stored_keys[kept++] = stored_keys[j];
          end
          fill = kept;
        end
        OP_TAKE: begin
          if (pos >= fill) begin
            r.status = STATUS_RANGE;
          end else begin
            r.taken_key = KEY_FIELD_W'(stored_keys[pos]);
            for (int j = pos; j + 1 < fill; j++) stored_keys[j] = stored_keys[j+1];
            fill--;
            r.removed_count = 1;
          end
        end
        default: ;  // unused opcode leaves the list alone
      endcase
      r.entry_count = CNT_W'(fill);
      return r;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [KEY_FIELD_W-1:0] key,
                               logic [POS_W-1:0] pos);
      reply_t want;
      want = predict_list_op(op, key, pos);
      expected_replies.insert(expected_replies.size(), want);
    endfunction

    function void check_result(reply_t got);
      reply_t want;
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_replies.pop_front();
      if (got.taken_key !== want.taken_key) begin
        $display("%0t: taken_key expected %h got %h", $time, want.taken_key, got.taken_key);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
        mismatches++;
      end
      if (got.entry_count !== want.entry_count) begin
        $display("%0t: entry_count expected %0d got %0d", $time, want.entry_count,
                 got.entry_count);
        mismatches++;
      end
      if (got.removed_count !== want.removed_count) begin
        $display("%0t: removed_count expected %0d got %0d", $time, want.removed_count,
                 got.removed_count);
        mismatches++;
      end
    endfunction
  endclass

  // Clock, reset and DUT pins; every input is known from time zero
  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic [OP_W-1:0]        opcode    = OP_INSERT;
  logic [KEY_FIELD_W-1:0] key_in    = '0;
  logic [POS_W-1:0]       position  = '0;
  logic                   out_stall = 1'b0;
  logic                   in_stall_o;
  logic                   out_valid_o;
  logic [KEY_FIELD_W-1:0] taken_key_o;
  logic [STATUS_W-1:0]    status_o;
  logic [CNT_W-1:0]       entry_count_o;
  logic [CNT_W-1:0]       removed_count_o;

  // calm: both sides run without idle cycles
  // hold_off_req: the result side takes one long break at its next transaction
  bit                     calm         = 1'b0;
  bit                     hold_off_req = 1'b0;
  int unsigned            cycle_count  = 0;
  logic [KEY_FIELD_W-1:0] key_pool [8];
  list_tracker            tracker;

  sorted_list_insert_remove_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode),
    .key_i           (key_in),
    .position_i      (position),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .taken_key_o     (taken_key_o),
    .status_o        (status_o),
    .entry_count_o   (entry_count_o),
    .removed_count_o (removed_count_o)
  );

  always #5 clk = ~clk;

  // Run guard: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result monitor: samples pre-edge values, so it sees what the edge accepts
  always @(posedge clk) begin : result_monitor
    reply_t got;
    if (rst_n && out_valid_o && !out_stall) begin
      got.taken_key     = taken_key_o;
      got.status        = status_e'(status_o);
      got.entry_count   = entry_count_o;
      got.removed_count = removed_count_o;
      tracker.check_result(got);
    end
  end

  // Result side: draws a stall length per transaction, 0 in calm phases.
  // A long hold-off lets the unit fill its output register and stall its input.
  initial begin : result_sink
    int unsigned wait_cycles;
    @(posedge rst_n);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        wait_cycles  = HOLD_OFF_CYCLES;
      end else if (calm) begin
        wait_cycles = 0;
      end else begin
        wait_cycles = $urandom_range(0, MAX_GAP);
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid_o);
    end
  end

  // Offer one request transaction and record it once the unit accepts it.
  // valid only drops when there is a gap, so it never toggles within a step.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_FIELD_W-1:0] key,
                              input logic [POS_W-1:0] pos);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    key_in   <= key;
    position <= pos;
    do @(posedge clk); while (in_stall_o);
    tracker.note_request(op, key, pos);
  endtask

  // Mostly keys from a small pool so that equal runs build up and removes hit
  function automatic logic [KEY_FIELD_W-1:0] pick_key();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll <= 5) return key_pool[$urandom_range(0, 7)];
    if (roll <= 8) return $urandom;
    return $urandom_range(0, 1) ? '1 : '0;
  endfunction

  // Take positions lean toward live entries, with some anywhere in range
  function automatic logic [POS_W-1:0] pick_position();
    int unsigned n;
    n = tracker.entry_count();
    if (n == 0 || $urandom_range(0, 3) == 0) return POS_W'($urandom_range(0, 15));
    return POS_W'($urandom_range(0, n - 1));
  endfunction

  initial begin : stimulus
    int unsigned      roll;
    bit               growing;
    logic [OP_W-1:0]  op;
    tracker = new();
    key_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h0000_0001, 32'h5555_AAAA, 32'h0000_002A, 32'h0000_002B};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed prelude, no idling
    calm = 1'b1;
    send_request(OP_UNUSED, '1, 4'd15);         // unused opcode on empty list
    send_request(OP_TAKE, '0, 4'd0);            // take beyond count on empty list
    send_request(OP_REMOVE, '0, 4'd0);          // remove of absent key
    send_request(OP_INSERT, 32'd7, 4'd0);
    send_request(OP_INSERT, 32'd7, 4'd0);       // equal key goes in front
    send_request(OP_INSERT, '0, 4'd0);
    send_request(OP_INSERT, '1, 4'd0);
    repeat (12) send_request(OP_INSERT, 32'h8000_0000, 4'd0);
    send_request(OP_INSERT, 32'd1, 4'd0);       // insert into full list
    send_request(OP_TAKE, '0, 4'd15);           // last entry of a full list
    send_request(OP_TAKE, '0, 4'd15);           // now beyond count
    send_request(OP_REMOVE, 32'h8000_0000, 4'd0);  // long closing run
    send_request(OP_REMOVE, 32'd7, 4'd0);
    send_request(OP_TAKE, '0, 4'd0);

    // Random phases: fill-leaning and drain-leaning in turn
    for (int unsigned item = 0; item < RANDOM_ITEMS; item++) begin
      if (item % PHASE_LEN == 0) begin
        growing = ((item / PHASE_LEN) % 2) == 0;
        calm    = ((item / PHASE_LEN) % 4) == 3;
        for (int i = 4; i < 8; i++) key_pool[i] = $urandom;
        if (item / PHASE_LEN == 5) hold_off_req = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < (growing ? 60 : 30))      op = OP_INSERT;
      else if (roll < (growing ? 75 : 55)) op = OP_REMOVE;
      else if (roll < 97)                  op = OP_TAKE;
      else                                 op = OP_UNUSED;
      send_request(op, pick_key(), pick_position());
    end
    in_valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/sli_pkg.sv
design/sli_cell.sv
design/sli_ctrl.sv
design/sorted_list_insert_remove_unit.sv
dv/tb.sv
